>>> rtl/core/cpef_pkg.sv
// shared types and constants of the column profile edge finder
package cpef_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 18;
  localparam int EDGE_W     = 10;
  localparam int DIM_W      = 11;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
  localparam logic [THR_W-1:0] RST_THRESHOLD    = 16'd160;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    B_RUN,
    B_REF,
    B_LIMIT,
    B_SETUP,
    B_SCAN,
    B_DONE
  } back_state_e;

  typedef struct packed {
    logic start;
    logic eof;
  } pix_ctl_t;

  typedef struct packed {
    logic [EDGE_W-1:0] left_edge;
    logic              left_found;
    logic [EDGE_W-1:0] right_edge;
    logic              right_found;
  } result_t;

endpackage

>>> rtl/core/cpef_pixel_if.sv
// pixel request channel
interface cpef_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [cpef_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

>>> rtl/core/cpef_result_if.sv
// edge result request channel
interface cpef_result_if;
  logic                        valid;
  logic                        ready;
  logic [cpef_pkg::EDGE_W-1:0] left_edge;
  logic                        left_found;
  logic [cpef_pkg::EDGE_W-1:0] right_edge;
  logic                        right_found;

  modport source (output valid, output left_edge, output left_found,
                  output right_edge, output right_found, input ready);
  modport sink (input valid, input left_edge, input left_found,
                input right_edge, input right_found, output ready);
endinterface

>>> rtl/core/column_profile_edge_finder.sv
// top level of the column profile edge finder
// Pixels of a grayscale frame arrive in raster order and are taken one per
// cycle outside the edge search; each is added into an 18-bit running sum
// for its column, held in a single-port-read column sum memory. After the
// last pixel of a frame the block reads the center column (width/2) and
// walks outward, first to the left and then to the right, one column read
// per cycle, looking for the first column that, together with its outward
// neighbour, differs from the center by more than the threshold
// (16*|sum-center| > threshold_q4*height). Once the last pixel's sum is
// written, the search, which waits if needed for the previous result to be
// taken, produces one result per frame; while it runs, up to two pixels of
// the next frame are buffered and further pixels are held off. Sums are
// restarted at each frame start by a fill count, so there is no clearing
// pass after reset. Width and height are saturated to 1..MAX_COLUMNS and 1..MAX_ROWS.
module column_profile_edge_finder #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  cpef_pixel_if.sink                          pixel_i,
  cpef_result_if.source                       result_o,
  input  logic                                cfg_we_i,
  input  logic [cpef_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cpef_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int XW = $clog2(MAX_COLUMNS);
  localparam int CW = $clog2(MAX_COLUMNS+1);
  localparam int HW = $clog2(MAX_ROWS+1);
  localparam int QW = XW + cpef_pkg::PIX_W + $bits(cpef_pkg::pix_ctl_t);

  logic [cpef_pkg::DIM_W-1:0] image_width_q;
  logic [cpef_pkg::DIM_W-1:0] image_height_q;
  logic [cpef_pkg::THR_W-1:0] threshold_q;
  logic [CW-1:0]              width_eff;
  logic [HW-1:0]              height_eff;

  logic                       push_ready;
  logic                       accept;
  logic [XW-1:0]              front_col;
  cpef_pkg::pix_ctl_t         front_ctl;
  logic                       q_valid;
  logic                       q_ready;
  logic [QW-1:0]              q_data;
  logic [XW-1:0]              q_col;
  logic [cpef_pkg::PIX_W-1:0] q_pix;
  cpef_pkg::pix_ctl_t         q_ctl;
  cpef_pkg::result_t          result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= cpef_pkg::RST_IMAGE_WIDTH;
      image_height_q <= cpef_pkg::RST_IMAGE_HEIGHT;
      threshold_q    <= cpef_pkg::RST_THRESHOLD;
    end else if (cfg_we_i) begin
      unique case (cpef_pkg::cfg_reg_e'(cfg_idx_i))
        cpef_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata_i[cpef_pkg::DIM_W-1:0];
        cpef_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata_i[cpef_pkg::DIM_W-1:0];
        cpef_pkg::CFG_THRESHOLD:    threshold_q    <= cfg_wdata_i[cpef_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width_q == '0) begin
      width_eff = CW'(1);
    end else if (32'(image_width_q) > MAX_COLUMNS) begin
      width_eff = CW'(MAX_COLUMNS);
    end else begin
      width_eff = CW'(image_width_q);
    end
    if (image_height_q == '0) begin
      height_eff = HW'(1);
    end else if (32'(image_height_q) > MAX_ROWS) begin
      height_eff = HW'(MAX_ROWS);
    end else begin
      height_eff = HW'(image_height_q);
    end
  end

  assign pixel_i.ready = push_ready;
  assign accept        = pixel_i.valid && push_ready;

  cpef_front #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .width_i  (width_eff),
    .height_i (height_eff),
    .col_o    (front_col),
    .ctl_o    (front_ctl)
  );

  cpef_queue #(
    .W (QW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (pixel_i.valid),
    .push_ready_o (push_ready),
    .push_data_i  ({front_col, pixel_i.pixel, front_ctl}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  assign {q_col, q_pix, q_ctl} = q_data;

  cpef_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_valid),
    .pop_ready_o (q_ready),
    .col_i       (q_col),
    .pixel_i     (q_pix),
    .ctl_i       (q_ctl),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .thresh_i    (threshold_q),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .result_o    (result)
  );

  assign result_o.left_edge   = result.left_edge;
  assign result_o.left_found  = result.left_found;
  assign result_o.right_edge  = result.right_edge;
  assign result_o.right_found = result.right_found;

endmodule

>>> rtl/core/cpef_front.sv
// raster position tracking and pixel classification
module cpef_front #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    accept_i,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]        width_i,
  input  logic [$clog2(MAX_ROWS+1)-1:0]           height_i,
  output logic [$clog2(MAX_COLUMNS)-1:0]          col_o,
  output cpef_pkg::pix_ctl_t                      ctl_o
);

  localparam int XW = $clog2(MAX_COLUMNS);
  localparam int AW = XW + 1;
  localparam int YW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW = YW + 1;

  logic [XW-1:0] col_pos_q, col_pos_d;
  logic [YW-1:0] row_pos_q, row_pos_d;
  logic [XW-1:0] col;
  logic          more_cols;
  logic          more_rows;

  always_comb begin
    if (AW'(col_pos_q) >= AW'(width_i)) begin
      col = XW'(width_i - 1'b1);
    end else begin
      col = col_pos_q;
    end
    more_cols = (AW'(col) + AW'(1)) < AW'(width_i);
    more_rows = (RW'(row_pos_q) + RW'(1)) < RW'(height_i);

    col_pos_d = col_pos_q;
    row_pos_d = row_pos_q;
    if (accept_i) begin
      if (more_cols) begin
        col_pos_d = col + XW'(1);
      end else begin
        col_pos_d = '0;
        row_pos_d = more_rows ? (row_pos_q + YW'(1)) : '0;
      end
    end
  end

  assign col_o       = col;
  assign ctl_o.start = (col == '0) && (row_pos_q == '0);
  assign ctl_o.eof   = !more_cols && !more_rows;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else begin
      col_pos_q <= col_pos_d;
      row_pos_q <= row_pos_d;
    end
  end

endmodule

>>> rtl/core/cpef_queue.sv
// two-entry request queue between front and back
module cpef_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);

  logic [W-1:0] data_q [2];
  logic         wr_ptr_q;
  logic         rd_ptr_q;
  logic [1:0]   cnt_q, cnt_d;
  logic         push;
  logic         pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = data_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/core/cpef_back.sv
// column sum accumulation and outward edge search
module cpef_back #(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               pop_valid_i,
  output logic                               pop_ready_o,
  input  logic [$clog2(MAX_COLUMNS)-1:0]     col_i,
  input  logic [cpef_pkg::PIX_W-1:0]         pixel_i,
  input  cpef_pkg::pix_ctl_t                 ctl_i,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]   width_i,
  input  logic [$clog2(MAX_ROWS+1)-1:0]      height_i,
  input  logic [cpef_pkg::THR_W-1:0]         thresh_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output cpef_pkg::result_t                  result_o
);

  localparam int XW    = $clog2(MAX_COLUMNS);
  localparam int AW    = XW + 1;
  localparam int CW    = $clog2(MAX_COLUMNS+1);
  localparam int HW    = $clog2(MAX_ROWS+1);
  localparam int LW    = cpef_pkg::THR_W + HW;
  localparam int DW    = cpef_pkg::SUM_W + 4;
  localparam int CMP_W = (LW > DW) ? LW : DW;
  localparam int SW    = cpef_pkg::SUM_W;

  logic [SW-1:0] mem [MAX_COLUMNS];
  logic [SW-1:0] rdata_q;
  logic          rd_live_q;
  logic [XW-1:0] rd_addr;

  logic [CW-1:0] hw_q, hw_d;
  logic          pop;
  logic          fresh;

  logic                       s2_v_q;
  logic                       s2_eof_q;
  logic                       s2_fresh_q;
  logic [XW-1:0]              s2_col_q;
  logic [cpef_pkg::PIX_W-1:0] s2_pix_q;

  logic          wr_v_q;
  logic [XW-1:0] wr_col_q;
  logic [SW-1:0] wr_sum_q;
  logic [SW-1:0] base;
  logic [SW-1:0] sum;

  cpef_pkg::back_state_e state_q, state_d;
  logic          dir_q, dir_d;
  logic [XW-1:0] scan_q, scan_d;
  logic          issue_q, issue_d;
  logic          cmp_v_q, cmp_v_d;
  logic [XW-1:0] cmp_col_q, cmp_col_d;
  logic          prev_q, prev_d;
  logic [XW-1:0] le_q, le_d, re_q, re_d;
  logic          lf_q, lf_d, rf_q, rf_d;
  logic          out_v_q;
  logic          out_load;
  cpef_pkg::result_t out_q;

  logic [SW-1:0] center_sum_q;
  logic [LW-1:0] limit_q;
  logic [XW-1:0] center;
  logic [XW-1:0] lim;
  logic [SW-1:0] rd_val;
  logic [SW-1:0] diff;
  logic          qual;

  assign pop_ready_o = (state_q == cpef_pkg::B_RUN) && !(s2_v_q && s2_eof_q);
  assign pop         = pop_valid_i && pop_ready_o;
  assign fresh       = ctl_i.start || (AW'(col_i) >= AW'(hw_q));
  assign center      = XW'(width_i >> 1);
  assign lim         = dir_q ? XW'(width_i - 1'b1) : '0;

  // first write of a column in a frame starts from zero
  always_comb begin
    hw_d = hw_q;
    if (pop) begin
      if (ctl_i.start) begin
        hw_d = CW'(1);
      end else if (fresh) begin
        hw_d = CW'(AW'(col_i) + AW'(1));
      end
    end
  end

  always_comb begin
    if (s2_fresh_q) begin
      base = '0;
    end else if (wr_v_q && (wr_col_q == s2_col_q)) begin
      base = wr_sum_q;
    end else begin
      base = rdata_q;
    end
    sum = base + SW'(s2_pix_q);
  end

  always_comb begin
    case (state_q)
      cpef_pkg::B_RUN:  rd_addr = col_i;
      cpef_pkg::B_SCAN: rd_addr = scan_q;
      default:          rd_addr = center;
    endcase
  end

  always_comb begin
    rd_val = rd_live_q ? rdata_q : '0;
    diff   = (rd_val > center_sum_q) ? (rd_val - center_sum_q) : (center_sum_q - rd_val);
    qual   = CMP_W'({diff, 4'b0000}) > CMP_W'(limit_q);
  end

  always_comb begin
    state_d   = state_q;
    dir_d     = dir_q;
    scan_d    = scan_q;
    issue_d   = issue_q;
    cmp_v_d   = 1'b0;
    cmp_col_d = cmp_col_q;
    prev_d    = prev_q;
    le_d      = le_q;
    lf_d      = lf_q;
    re_d      = re_q;
    rf_d      = rf_q;
    out_load  = 1'b0;
    unique case (state_q)
      cpef_pkg::B_RUN: begin
        if (s2_v_q && s2_eof_q) begin
          state_d = cpef_pkg::B_REF;
        end
      end
      cpef_pkg::B_REF: begin
        le_d    = '0;
        lf_d    = 1'b0;
        re_d    = '0;
        rf_d    = 1'b0;
        state_d = cpef_pkg::B_LIMIT;
      end
      cpef_pkg::B_LIMIT: begin
        dir_d   = 1'b0;
        state_d = cpef_pkg::B_SETUP;
      end
      cpef_pkg::B_SETUP: begin
        prev_d  = 1'b0;
        issue_d = 1'b0;
        if (!dir_q) begin
          if (center != '0) begin
            scan_d  = center - XW'(1);
            issue_d = 1'b1;
            state_d = cpef_pkg::B_SCAN;
          end else begin
            dir_d = 1'b1;
          end
        end else begin
          if ((AW'(center) + AW'(1)) < AW'(width_i)) begin
            scan_d  = center + XW'(1);
            issue_d = 1'b1;
            state_d = cpef_pkg::B_SCAN;
          end else begin
            state_d = cpef_pkg::B_DONE;
          end
        end
      end
      cpef_pkg::B_SCAN: begin
        cmp_v_d   = issue_q;
        cmp_col_d = scan_q;
        if (issue_q) begin
          if (scan_q == lim) begin
            issue_d = 1'b0;
          end else begin
            scan_d = dir_q ? (scan_q + XW'(1)) : (scan_q - XW'(1));
          end
        end
        if (cmp_v_q) begin
          prev_d = qual;
          if (prev_q && qual) begin
            if (!dir_q) begin
              le_d    = cmp_col_q + XW'(1);
              lf_d    = 1'b1;
              dir_d   = 1'b1;
              state_d = cpef_pkg::B_SETUP;
            end else begin
              re_d    = cmp_col_q - XW'(1);
              rf_d    = 1'b1;
              state_d = cpef_pkg::B_DONE;
            end
          end else if (cmp_col_q == lim) begin
            if (!dir_q) begin
              dir_d   = 1'b1;
              state_d = cpef_pkg::B_SETUP;
            end else begin
              state_d = cpef_pkg::B_DONE;
            end
          end
        end
      end
      cpef_pkg::B_DONE: begin
        if (!out_v_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = cpef_pkg::B_RUN;
        end
      end
      default: begin
        state_d = cpef_pkg::B_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cpef_pkg::B_RUN;
      dir_q   <= 1'b0;
      issue_q <= 1'b0;
      cmp_v_q <= 1'b0;
      prev_q  <= 1'b0;
      lf_q    <= 1'b0;
      rf_q    <= 1'b0;
      hw_q    <= '0;
      s2_v_q  <= 1'b0;
      wr_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
      issue_q <= issue_d;
      cmp_v_q <= cmp_v_d;
      prev_q  <= prev_d;
      lf_q    <= lf_d;
      rf_q    <= rf_d;
      hw_q    <= hw_d;
      s2_v_q  <= pop;
      if (s2_v_q) begin
        wr_v_q <= 1'b1;
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    cmp_col_q <= cmp_col_d;
    le_q      <= le_d;
    re_q      <= re_d;
    rd_live_q <= AW'(rd_addr) < AW'(hw_q);
    if (pop) begin
      s2_eof_q   <= ctl_i.eof;
      s2_fresh_q <= fresh;
      s2_col_q   <= col_i;
      s2_pix_q   <= pixel_i;
    end
    if (s2_v_q) begin
      wr_col_q <= s2_col_q;
      wr_sum_q <= sum;
    end
    if (state_q == cpef_pkg::B_REF) begin
      limit_q <= LW'(thresh_i) * LW'(height_i);
    end
    if (state_q == cpef_pkg::B_LIMIT) begin
      center_sum_q <= rd_val;
    end
    if (out_load) begin
      out_q.left_edge   <= cpef_pkg::EDGE_W'(le_q);
      out_q.left_found  <= lf_q;
      out_q.right_edge  <= cpef_pkg::EDGE_W'(re_q);
      out_q.right_found <= rf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      mem[s2_col_q] <= sum;
    end
    rdata_q <= mem[rd_addr];
  end

  assign out_valid_o = out_v_q;
  assign result_o    = out_q;

`ifndef SYNTH
  a_eof_starts_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_eof_q) |=> (state_q == cpef_pkg::B_REF))
    else $error("last pixel of frame did not start the edge search");

  a_no_write_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != cpef_pkg::B_RUN) |-> !s2_v_q)
    else $error("column sum written during edge search");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> ($past(state_q) == cpef_pkg::B_DONE))
    else $error("result raised outside of search completion");
`endif

endmodule
